// File: hdl/cag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cag_pkg
// Shared types, constants and the cell successor function for the cyclic
// automaton grid step unit.
// ----------------------------------------------------------------------------
package cag_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CELL_W      = 3;
    localparam int INDEX_W     = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_DIM_W   = 9;
    localparam int CFG_STATE_W = 4;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [CFG_DIM_W-1:0]   RST_GRID_WIDTH  = 9'd256;
    localparam logic [CFG_DIM_W-1:0]   RST_GRID_HEIGHT = 9'd256;
    localparam logic [CFG_STATE_W-1:0] RST_STATE_COUNT = 4'd7;
    localparam logic [CFG_STATE_W-1:0] MIN_STATES      = 4'd2;
    localparam logic [CFG_STATE_W-1:0] MAX_STATES      = 4'd8;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_STATE_COUNT = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PRIME,
        ST_ADV0,
        ST_ADV1,
        ST_FLUSH
    } t_state;

    // effective (clamped) configuration
    typedef struct packed {
        logic [CFG_DIM_W-1:0]   width;
        logic [CFG_DIM_W-1:0]   height;
        logic [CFG_STATE_W-1:0] states;
    } t_cfg;

    typedef struct packed {
        logic we_a;
        logic we_b;
    } t_bank_we;

    // (value + 1) mod states, states in 2..8, so at most four subtractions
    function automatic logic [CELL_W-1:0] succ(input logic [CELL_W-1:0] value,
                                               input logic [CFG_STATE_W-1:0] states);
        logic [CFG_STATE_W-1:0] v;
        v = {1'b0, value} + 4'd1;
        for (int k = 0; k < 4; k++) begin
            if (v >= states) begin
                v = v - states;
            end
        end
        return v[CELL_W-1:0];
    endfunction

endpackage

// File: hdl/cag_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cag_regs
// APB configuration registers with clamping to the usable grid and state
// ranges.
// ----------------------------------------------------------------------------
module cag_regs #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cag_pkg::APB_AW-1:0] paddr,
    input  logic [cag_pkg::APB_DW-1:0] pwdata,
    output logic [cag_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output cag_pkg::t_cfg              o_cfg
);

    logic [cag_pkg::CFG_DIM_W-1:0]   r_grid_width;
    logic [cag_pkg::CFG_DIM_W-1:0]   r_grid_height;
    logic [cag_pkg::CFG_STATE_W-1:0] r_state_count;
    cag_pkg::t_reg_idx               reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cag_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= cag_pkg::RST_GRID_WIDTH;
            r_grid_height <= cag_pkg::RST_GRID_HEIGHT;
            r_state_count <= cag_pkg::RST_STATE_COUNT;
        end else if (wr_en) begin
            unique case (reg_idx)
                cag_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[cag_pkg::CFG_DIM_W-1:0];
                cag_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[cag_pkg::CFG_DIM_W-1:0];
                cag_pkg::REG_STATE_COUNT: r_state_count <= pwdata[cag_pkg::CFG_STATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cag_pkg::REG_GRID_WIDTH:
                prdata = {{(cag_pkg::APB_DW-cag_pkg::CFG_DIM_W){1'b0}}, r_grid_width};
            cag_pkg::REG_GRID_HEIGHT:
                prdata = {{(cag_pkg::APB_DW-cag_pkg::CFG_DIM_W){1'b0}}, r_grid_height};
            cag_pkg::REG_STATE_COUNT:
                prdata = {{(cag_pkg::APB_DW-cag_pkg::CFG_STATE_W){1'b0}}, r_state_count};
            default:
                prdata = '0;
        endcase
    end

    // clamp to 1..MAX and 2..8
    always_comb begin
        if (r_grid_width == '0) begin
            o_cfg.width = cag_pkg::CFG_DIM_W'(1);
        end else if (r_grid_width > MAX_WIDTH) begin
            o_cfg.width = cag_pkg::CFG_DIM_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_grid_width;
        end

        if (r_grid_height == '0) begin
            o_cfg.height = cag_pkg::CFG_DIM_W'(1);
        end else if (r_grid_height > MAX_HEIGHT) begin
            o_cfg.height = cag_pkg::CFG_DIM_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_grid_height;
        end

        if (r_state_count < cag_pkg::MIN_STATES) begin
            o_cfg.states = cag_pkg::MIN_STATES;
        end else if (r_state_count > cag_pkg::MAX_STATES) begin
            o_cfg.states = cag_pkg::MAX_STATES;
        end else begin
            o_cfg.states = r_state_count;
        end
    end

endmodule

// File: hdl/cag_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cag_bank
// One grid bank: single write port, two registered read ports.
// ----------------------------------------------------------------------------
module cag_bank #(
    parameter int DEPTH = cag_pkg::DEF_MAX_WIDTH * cag_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [cag_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr_0,
    input  logic [AW-1:0]              i_raddr_1,
    output logic [cag_pkg::CELL_W-1:0] o_rdata_0,
    output logic [cag_pkg::CELL_W-1:0] o_rdata_1
);

    logic [cag_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_0 <= mem[i_raddr_0];
        o_rdata_1 <= mem[i_raddr_1];
    end

endmodule

// File: hdl/cag_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cag_ctrl
// Item sequencer: cell writes and reads on the current bank, and the
// generation sweep that reads the current bank and writes the other one.
// ----------------------------------------------------------------------------
module cag_ctrl #(
    parameter int DEPTH = cag_pkg::DEF_MAX_WIDTH * cag_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cag_pkg::t_cfg               i_cfg,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [cag_pkg::KIND_W-1:0]  i_kind,
    input  logic [cag_pkg::INDEX_W-1:0] i_cell_index,
    input  logic [cag_pkg::CELL_W-1:0]  i_cell_value,
    output logic                        o_strobe,
    output logic [cag_pkg::CELL_W-1:0]  o_read_value,
    output cag_pkg::t_bank_we           o_bank_we,
    output logic [AW-1:0]               o_waddr,
    output logic [cag_pkg::CELL_W-1:0]  o_wdata,
    output logic [AW-1:0]               o_raddr_0,
    output logic [AW-1:0]               o_raddr_1,
    input  logic [cag_pkg::CELL_W-1:0]  i_bank_a_rd0,
    input  logic [cag_pkg::CELL_W-1:0]  i_bank_a_rd1,
    input  logic [cag_pkg::CELL_W-1:0]  i_bank_b_rd0,
    input  logic [cag_pkg::CELL_W-1:0]  i_bank_b_rd1
);

    localparam int SW = CW + 1;

    cag_pkg::t_state r_state, n_state;
    cag_pkg::t_kind  kind;

    logic                          r_active;
    logic                          r_first;
    logic                          r_oor;
    logic [CW-1:0]                 r_idx;
    logic [cag_pkg::CFG_DIM_W-1:0] r_col;
    logic [cag_pkg::CELL_W-1:0]    r_left;
    logic [cag_pkg::CELL_W-1:0]    r_center;
    logic [cag_pkg::CELL_W-1:0]    r_right;
    logic [cag_pkg::CELL_W-1:0]    r_up;
    logic [AW-1:0]                 r_paddr;
    logic                          r_has_left;
    logic                          r_has_right;
    logic                          r_has_up;
    logic                          r_has_down;

    logic [2*cag_pkg::CFG_DIM_W-1:0] area;
    logic [CW-1:0]                   total;
    logic [SW-1:0]                   w_ext;
    logic [SW-1:0]                   idx_ext;
    logic                            in_range;
    logic                            last_cell;
    logic                            col_wrap;
    logic [cag_pkg::CELL_W-1:0]      rd0;
    logic [cag_pkg::CELL_W-1:0]      rd1;
    logic [cag_pkg::CELL_W-1:0]      s_val;
    logic                            hit;
    logic [cag_pkg::CELL_W-1:0]      new_val;
    logic                            accept;

    assign kind      = cag_pkg::t_kind'(i_kind);
    assign area      = i_cfg.width * i_cfg.height;
    assign total     = CW'(area);
    assign w_ext     = SW'(i_cfg.width);
    assign idx_ext   = SW'(r_idx);
    assign in_range  = i_cell_index < total;
    assign last_cell = (idx_ext + SW'(1)) == SW'(total);
    assign col_wrap  = ({1'b0, r_col} + 10'd1) == {1'b0, i_cfg.width};
    assign accept    = i_start && (r_state == cag_pkg::ST_IDLE);

    // current bank holds the live generation
    assign rd0 = r_active ? i_bank_b_rd0 : i_bank_a_rd0;
    assign rd1 = r_active ? i_bank_b_rd1 : i_bank_a_rd1;

    // rd1 carries the lower neighbor of the cell being finished
    assign s_val   = cag_pkg::succ(r_center, i_cfg.states);
    assign hit     = (r_has_left  && (r_left   == s_val)) ||
                     (r_has_right && (r_right  == s_val)) ||
                     (r_has_up    && (r_up     == s_val)) ||
                     (r_has_down  && (rd1      == s_val));
    assign new_val = hit ? s_val : r_center;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cag_pkg::ST_IDLE: begin
                if (i_start) begin
                    priority case (kind)
                        cag_pkg::KIND_READ:    n_state = cag_pkg::ST_READ;
                        cag_pkg::KIND_ADVANCE: n_state = cag_pkg::ST_PRIME;
                        default:               n_state = cag_pkg::ST_IDLE;
                    endcase
                end
            end
            cag_pkg::ST_READ:  n_state = cag_pkg::ST_IDLE;
            cag_pkg::ST_PRIME: n_state = cag_pkg::ST_ADV0;
            cag_pkg::ST_ADV0:  n_state = cag_pkg::ST_ADV1;
            cag_pkg::ST_ADV1:  n_state = last_cell ? cag_pkg::ST_FLUSH : cag_pkg::ST_ADV0;
            cag_pkg::ST_FLUSH: n_state = cag_pkg::ST_IDLE;
            default:           n_state = cag_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy         = r_state != cag_pkg::ST_IDLE;
        o_strobe       = 1'b0;
        o_read_value   = '0;
        o_bank_we.we_a = 1'b0;
        o_bank_we.we_b = 1'b0;
        o_waddr        = r_paddr;
        o_wdata        = new_val;
        o_raddr_0      = AW'(idx_ext + SW'(1));
        o_raddr_1      = AW'(idx_ext - w_ext);
        unique case (r_state)
            cag_pkg::ST_IDLE: begin
                o_raddr_0 = AW'(i_cell_index);
                o_waddr   = AW'(i_cell_index);
                o_wdata   = i_cell_value;
                if (accept && (kind == cag_pkg::KIND_WRITE) && in_range) begin
                    o_bank_we.we_a = !r_active;
                    o_bank_we.we_b = r_active;
                end
            end
            cag_pkg::ST_READ: begin
                o_strobe     = 1'b1;
                o_read_value = r_oor ? '0 : rd0;
            end
            cag_pkg::ST_PRIME: begin
                o_raddr_0 = '0;
            end
            cag_pkg::ST_ADV0: begin
                if (!r_first) begin
                    o_bank_we.we_a = r_active;
                    o_bank_we.we_b = !r_active;
                end
            end
            cag_pkg::ST_ADV1: begin
                o_raddr_1 = AW'(idx_ext + w_ext);
            end
            cag_pkg::ST_FLUSH: begin
                o_bank_we.we_a = r_active;
                o_bank_we.we_b = !r_active;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cag_pkg::ST_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cag_pkg::ST_FLUSH) begin
                r_active <= !r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cag_pkg::ST_IDLE: begin
                r_oor <= !in_range;
            end
            cag_pkg::ST_PRIME: begin
                r_first <= 1'b1;
                r_idx   <= '0;
                r_col   <= '0;
            end
            cag_pkg::ST_ADV0: begin
                if (r_first) begin
                    r_center <= rd0;
                end else begin
                    r_left   <= r_center;
                    r_center <= r_right;
                end
            end
            cag_pkg::ST_ADV1: begin
                r_right     <= rd0;
                r_up        <= rd1;
                r_paddr     <= AW'(r_idx);
                r_has_left  <= r_col != '0;
                r_has_right <= !col_wrap;
                r_has_up    <= idx_ext >= w_ext;
                r_has_down  <= (idx_ext + w_ext) < SW'(total);
                r_first     <= 1'b0;
                if (!last_cell) begin
                    r_idx <= r_idx + CW'(1);
                    r_col <= col_wrap ? '0 : r_col + cag_pkg::CFG_DIM_W'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/cyclic_automaton_grid_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_automaton_grid_step_unit
// Cyclic cellular automaton on a grid of 3-bit cells held in two banks.
// ----------------------------------------------------------------------------
// A write is taken while idle and never raises busy. A read raises busy for
// one cycle and its word appears on o_read_value with o_strobe in the cycle
// after start; there is no backpressure, so the word must be captured then.
// An advance keeps busy high through the whole sweep: each cell needs
// a read of its upper and of its lower neighbor, and both go through the
// second read port of the current bank, upper then lower, while the right
// neighbor rides along on the first port. The new generation is written to
// the other bank, which then becomes current. Banks hold no reset value;
// configure while busy is low.
module cyclic_automaton_grid_step_unit #(
    parameter int MAX_WIDTH  = cag_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cag_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cag_pkg::KIND_W-1:0]  i_kind,
    input  logic [cag_pkg::INDEX_W-1:0] i_cell_index,
    input  logic [cag_pkg::CELL_W-1:0]  i_cell_value,
    output logic                        o_strobe,
    output logic [cag_pkg::CELL_W-1:0]  o_read_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cag_pkg::APB_AW-1:0]  paddr,
    input  logic [cag_pkg::APB_DW-1:0]  pwdata,
    output logic [cag_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cag_pkg::t_cfg              cfg;
    cag_pkg::t_bank_we          bank_we;
    logic [AW-1:0]              waddr;
    logic [cag_pkg::CELL_W-1:0] wdata;
    logic [AW-1:0]              raddr_0;
    logic [AW-1:0]              raddr_1;
    logic [cag_pkg::CELL_W-1:0] a_rd0;
    logic [cag_pkg::CELL_W-1:0] a_rd1;
    logic [cag_pkg::CELL_W-1:0] b_rd0;
    logic [cag_pkg::CELL_W-1:0] b_rd1;

    cag_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cag_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_a (
        .i_clk     (i_clk),
        .i_we      (bank_we.we_a),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_0 (raddr_0),
        .i_raddr_1 (raddr_1),
        .o_rdata_0 (a_rd0),
        .o_rdata_1 (a_rd1)
    );

    cag_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_b (
        .i_clk     (i_clk),
        .i_we      (bank_we.we_b),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_0 (raddr_0),
        .i_raddr_1 (raddr_1),
        .o_rdata_0 (b_rd0),
        .o_rdata_1 (b_rd1)
    );

    cag_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_start      (start),
        .o_busy       (busy),
        .i_kind       (i_kind),
        .i_cell_index (i_cell_index),
        .i_cell_value (i_cell_value),
        .o_strobe     (o_strobe),
        .o_read_value (o_read_value),
        .o_bank_we    (bank_we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr_0    (raddr_0),
        .o_raddr_1    (raddr_1),
        .i_bank_a_rd0 (a_rd0),
        .i_bank_a_rd1 (a_rd1),
        .i_bank_b_rd0 (b_rd0),
        .i_bank_b_rd1 (b_rd1)
    );

endmodule

// File: hdl/cag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cag_checker
// Port-level checks on the command handshake and the read word strobe.
// ----------------------------------------------------------------------------
module cag_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [cag_pkg::KIND_W-1:0] i_kind,
    input logic                       o_strobe
);

    // a word only comes out while the read is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("read word strobe outside busy");

    a_read_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == cag_pkg::KIND_READ)) |=> o_strobe)
        else $error("read did not return a word in the next cycle");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("one read produced more than one word");

    a_write_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_kind == cag_pkg::KIND_WRITE) ||
                            (i_kind == cag_pkg::KIND_NOP))) |=> (!busy && !o_strobe))
        else $error("write or no-op raised busy or a word");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("not idle after reset");

endmodule

bind cyclic_automaton_grid_step_unit cag_checker u_cag_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_kind   (i_kind),
    .o_strobe (o_strobe)
);

// File: dv/tb_cyclic_automaton_grid_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cyclic_automaton_grid_step_unit
// Self-checking bench for the cyclic automaton grid step unit. Write, read,
// advance and no-op words go in through the start/busy port, grid geometry
// and state count through the APB port. The bench keeps its own copy of both
// cell banks, steps it on every advance and checks each read word against it.
// ----------------------------------------------------------------------------
module tb_cyclic_automaton_grid_step_unit;

    localparam int GRID_CELLS   = cag_pkg::DEF_MAX_WIDTH * cag_pkg::DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_LIMIT  = 2 * GRID_CELLS + 16;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 24;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [cag_pkg::KIND_W-1:0]          i_kind;
    logic [cag_pkg::INDEX_W-1:0]         i_cell_index;
    logic [cag_pkg::CELL_W-1:0]          i_cell_value;
    logic                                o_strobe;
    logic [cag_pkg::CELL_W-1:0]          o_read_value;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [cag_pkg::APB_AW-1:0]          paddr;
    logic [cag_pkg::APB_DW-1:0]          pwdata;
    logic [cag_pkg::APB_DW-1:0]          prdata;
    logic                                pready;

    // model of the grid: both banks, which cells hold a written value
    logic [cag_pkg::CELL_W-1:0]          cell_mem [2][GRID_CELLS];
    bit                                  cell_known [2][GRID_CELLS];
    bit                                  cur_bank = 1'b0;
    logic [cag_pkg::CFG_DIM_W-1:0]       reg_width = cag_pkg::RST_GRID_WIDTH;
    logic [cag_pkg::CFG_DIM_W-1:0]       reg_height = cag_pkg::RST_GRID_HEIGHT;
    logic [cag_pkg::CFG_STATE_W-1:0]     reg_states = cag_pkg::RST_STATE_COUNT;
    logic [cag_pkg::CELL_W-1:0]          read_expect_q [$];

    int                                  idle_pct = 0;
    int                                  error_count = 0;
    int                                  cycle_count = 0;

    cyclic_automaton_grid_step_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_cell_index (i_cell_index),
        .i_cell_value (i_cell_value),
        .o_strobe     (o_strobe),
        .o_read_value (o_read_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int grid_cols();
        if (reg_width < 1) return 1;
        if (reg_width > cag_pkg::DEF_MAX_WIDTH) return cag_pkg::DEF_MAX_WIDTH;
        return int'(reg_width);
    endfunction

    function automatic int grid_rows();
        if (reg_height < 1) return 1;
        if (reg_height > cag_pkg::DEF_MAX_HEIGHT) return cag_pkg::DEF_MAX_HEIGHT;
        return int'(reg_height);
    endfunction

    function automatic int state_mod();
        if (reg_states < cag_pkg::MIN_STATES) return int'(cag_pkg::MIN_STATES);
        if (reg_states > cag_pkg::MAX_STATES) return int'(cag_pkg::MAX_STATES);
        return int'(reg_states);
    endfunction

    function automatic int grid_total();
        return grid_cols() * grid_rows();
    endfunction

    // one generation of the four-neighbor rule, built into the other bank
    function automatic void step_generation();
        int w;
        int total;
        int m;
        int col;
        int nxt;
        int succ_int;
        logic [cag_pkg::CELL_W-1:0] v;
        logic [cag_pkg::CELL_W-1:0] s;
        bit hit;
        w = grid_cols();
        total = grid_total();
        m = state_mod();
        nxt = cur_bank ? 0 : 1;
        for (int i = 0; i < total; i++) begin
            col = i % w;
            v = cell_mem[cur_bank][i];
            succ_int = (int'(v) + 1) % m;
            s = succ_int[cag_pkg::CELL_W-1:0];
            hit = 1'b0;
            if (col + 1 < w && cell_mem[cur_bank][i + 1] == s) hit = 1'b1;
            if (col != 0 && cell_mem[cur_bank][i - 1] == s) hit = 1'b1;
            if (i >= w && cell_mem[cur_bank][i - w] == s) hit = 1'b1;
            if (i + w < total && cell_mem[cur_bank][i + w] == s) hit = 1'b1;
            cell_mem[nxt][i] = hit ? s : v;
            cell_known[nxt][i] = 1'b1;
        end
        cur_bank = ~cur_bank;
    endfunction

    function automatic void apply_item(cag_pkg::t_kind kind,
                                       logic [cag_pkg::INDEX_W-1:0] idx,
                                       logic [cag_pkg::CELL_W-1:0] val);
        int total;
        total = grid_total();
        case (kind)
            cag_pkg::KIND_WRITE: begin
                if (idx < total) begin
                    cell_mem[cur_bank][idx] = val;
                    cell_known[cur_bank][idx] = 1'b1;
                end
            end
            cag_pkg::KIND_READ: begin
                read_expect_q.push_back(idx < total ? cell_mem[cur_bank][idx] : '0);
            end
            cag_pkg::KIND_ADVANCE: begin
                step_generation();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [cag_pkg::CELL_W-1:0] pick_value();
        if ($urandom_range(9) == 0) return cag_pkg::CELL_W'($urandom_range(0, 7));
        return cag_pkg::CELL_W'($urandom_range(0, state_mod() - 1));
    endfunction

    function automatic logic [cag_pkg::CELL_W-1:0] any_value();
        return cag_pkg::CELL_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [cag_pkg::INDEX_W-1:0] any_index(int unsigned lo,
                                                              int unsigned hi);
        return cag_pkg::INDEX_W'($urandom_range(lo, hi));
    endfunction

    // random bits above the register field, which the register drops
    function automatic logic [cag_pkg::APB_DW-1:0] with_junk(int unsigned value, int field_w);
        logic [cag_pkg::APB_DW-1:0] junk;
        junk = ($urandom_range(3) == 0) ? ($urandom << field_w) : '0;
        return value | junk;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (read_expect_q.size() == 0) begin
                report_error($sformatf("read word with no read pending: got %0d",
                                       o_read_value));
            end else if (read_expect_q[0] !== o_read_value) begin
                report_error($sformatf("read word mismatch: expected %0d, got %0d",
                                       read_expect_q[0], o_read_value));
                void'(read_expect_q.pop_front());
            end else begin
                void'(read_expect_q.pop_front());
            end
        end
    end

    task automatic send_item(cag_pkg::t_kind kind, logic [cag_pkg::INDEX_W-1:0] idx,
                             logic [cag_pkg::CELL_W-1:0] val);
        start        <= 1'b1;
        i_kind       <= kind;
        i_cell_index <= idx;
        i_cell_value <= val;
        do @(posedge i_clk); while (busy);
        apply_item(kind, idx, val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || read_expect_q.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic config_write(cag_pkg::t_reg_idx r, logic [cag_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (r)
            cag_pkg::REG_GRID_WIDTH:  reg_width  = data[cag_pkg::CFG_DIM_W-1:0];
            cag_pkg::REG_GRID_HEIGHT: reg_height = data[cag_pkg::CFG_DIM_W-1:0];
            cag_pkg::REG_STATE_COUNT: reg_states = data[cag_pkg::CFG_STATE_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_geometry(int unsigned cols, int unsigned rows, int unsigned states);
        wait_quiet();
        config_write(cag_pkg::REG_GRID_WIDTH, with_junk(cols, cag_pkg::CFG_DIM_W));
        config_write(cag_pkg::REG_GRID_HEIGHT, with_junk(rows, cag_pkg::CFG_DIM_W));
        config_write(cag_pkg::REG_STATE_COUNT, with_junk(states, cag_pkg::CFG_STATE_W));
    endtask

    // an advance or a read may only touch cells that hold a written value
    task automatic fill_unknown();
        int total;
        total = grid_total();
        for (int i = 0; i < total; i++) begin
            if (!cell_known[cur_bank][i]) begin
                send_item(cag_pkg::KIND_WRITE, i[cag_pkg::INDEX_W-1:0], pick_value());
            end
        end
    endtask

    task automatic read_all();
        int total;
        total = grid_total();
        for (int i = 0; i < total; i++) begin
            send_item(cag_pkg::KIND_READ, i[cag_pkg::INDEX_W-1:0], any_value());
        end
    endtask

    task automatic test_directed();
        logic [cag_pkg::CELL_W-1:0] pattern [12];
        pattern = '{3'd0, 3'd1, 3'd2, 3'd3,
                    3'd3, 3'd0, 3'd7, 3'd5,
                    3'd1, 3'd2, 3'd0, 3'd3};
        idle_pct = 0;
        // reset geometry is 256 x 256, every index is in range
        send_item(cag_pkg::KIND_WRITE, 16'hFFFF, 3'd7);
        send_item(cag_pkg::KIND_WRITE, 16'h0000, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'hFFFF, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'h0000, 3'd7);
        send_item(cag_pkg::KIND_NOP, 16'hFFFF, 3'd7);
        // 4 x 3 grid, four states: 7 and 5 sit above the modulus, 3 wraps to 0
        set_geometry(4, 3, 4);
        for (int i = 0; i < 12; i++) begin
            send_item(cag_pkg::KIND_WRITE, i[cag_pkg::INDEX_W-1:0], pattern[i]);
        end
        send_item(cag_pkg::KIND_READ, 16'd11, 3'd0);
        send_item(cag_pkg::KIND_ADVANCE, 16'hFFFF, 3'd7);
        send_item(cag_pkg::KIND_READ, 16'd0, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd5, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd6, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd9, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd12, 3'd0);
        send_item(cag_pkg::KIND_WRITE, 16'd40, 3'd6);
        send_item(cag_pkg::KIND_READ, 16'd40, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'hFFFF, 3'd0);
    endtask

    task automatic test_register_extremes();
        idle_pct = 77;
        // all-ones width saturates to 256, two rows give 512 cells
        set_geometry(9'h1FF, 2, 8);
        send_item(cag_pkg::KIND_WRITE, 16'd511, 3'd6);
        send_item(cag_pkg::KIND_WRITE, 16'd512, 3'd3);
        send_item(cag_pkg::KIND_READ, 16'd511, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd512, 3'd0);
        // single column, all-ones height and state count saturate
        set_geometry(1, 9'h1FF, 15);
        send_item(cag_pkg::KIND_WRITE, 16'd255, 3'd2);
        send_item(cag_pkg::KIND_READ, 16'd255, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd256, 3'd0);
        // zero width and height leave one cell with no neighbors
        set_geometry(0, 0, 0);
        fill_unknown();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd0, 3'd0);
        send_item(cag_pkg::KIND_READ, 16'd1, 3'd0);
        set_geometry(2, 1, 1);
        fill_unknown();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
        read_all();
        set_geometry(3, 3, 9);
        fill_unknown();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
        send_item(cag_pkg::KIND_ADVANCE, 16'hA5A5, 3'd5);
        read_all();
    endtask

    task automatic test_resize();
        idle_pct = 36;
        set_geometry(3, 3, 5);
        fill_unknown();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
        read_all();
        // shrinking keeps linear storage, rows regroup
        set_geometry(2, 2, 5);
        fill_unknown();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
        read_all();
        // enlarging exposes what the current bank last held
        set_geometry(3, 3, 5);
        fill_unknown();
        read_all();
        send_item(cag_pkg::KIND_ADVANCE, 16'd0, 3'd0);
    endtask

    task automatic test_random_generations();
        int done;
        int round;
        int pick;
        int total;
        int phase_pct [3];
        phase_pct = '{0, 77, 36};
        done = 0;
        round = 0;
        while (done < RANDOM_ITEMS) begin
            set_geometry(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                         ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                         ($urandom_range(3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(2, 8));
            idle_pct = phase_pct[round % 3];
            fill_unknown();
            total = grid_total();
            repeat ($urandom_range(8, 14)) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    send_item(cag_pkg::KIND_WRITE, any_index(0, total - 1), pick_value());
                    done++;
                end else if (pick < 60) begin
                    if ($urandom_range(3) != 0) begin
                        send_item(cag_pkg::KIND_READ, any_index(0, total - 1), any_value());
                    end else begin
                        send_item(cag_pkg::KIND_READ, any_index(total, 65535), any_value());
                    end
                    done++;
                end else if (pick < 78) begin
                    send_item(cag_pkg::KIND_ADVANCE, any_index(0, 65535), any_value());
                    done++;
                end else if (pick < 88) begin
                    send_item(cag_pkg::KIND_NOP, any_index(0, 65535), any_value());
                end else if (pick < 95) begin
                    send_item(cag_pkg::KIND_WRITE, any_index(total, 65535), any_value());
                end else begin
                    // hold off until every read word is back
                    wait_quiet();
                end
            end
            round++;
        end
    endtask

    initial begin
        int n;
        start        <= 1'b0;
        i_kind       <= cag_pkg::KIND_NOP;
        i_cell_index <= '0;
        i_cell_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_resize();
        test_random_generations();

        start <= 1'b0;
        n = 0;
        while ((busy || read_expect_q.size() != 0) && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
        if (read_expect_q.size() != 0) begin
            report_error($sformatf("%0d read words never arrived", read_expect_q.size()));
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
